/* sv/mcmb_pkg.sv */
`timescale 1ns / 1ps

package mcmb_pkg;

    localparam int CHANNELS    = 32;
    localparam int QUEUE_DEPTH = 16;

    // Widths that follow from the channel count and the queue depth
    localparam int CIDX_W = $clog2(CHANNELS);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = CHANNELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(MEM_DEPTH);

    // Fixed field widths
    localparam int CHAN_W = 5;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;

    // Channels 1 .. CHANNELS-1
    localparam logic [WORD_W-1:0] VALID_MASK =
        WORD_W'((64'd1 << CHANNELS) - 64'd1) & 32'hFFFF_FFFE;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE    = 2'd3;

    typedef struct packed {
        logic exec;
        logic load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    function automatic logic [PTR_W-1:0] f_next_ptr(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (32'(ptr) >= 32'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + PTR_W'(1);
        end
        return res;
    endfunction

endpackage

/* sv/mcmb_in_if.sv */
`timescale 1ns / 1ps

interface mcmb_in_if;
    import mcmb_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [CHAN_W-1:0] channel;
    logic [WORD_W-1:0] message_command;
    logic [WORD_W-1:0] message_object;
    logic [WORD_W-1:0] receive_mask;

    modport source (
        output valid, command, channel, message_command, message_object, receive_mask,
        input  ready
    );

    modport sink (
        input  valid, command, channel, message_command, message_object, receive_mask,
        output ready
    );
endinterface

/* sv/mcmb_out_if.sv */
`timescale 1ns / 1ps

interface mcmb_out_if;
    import mcmb_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [CHAN_W-1:0] from_channel;
    logic [WORD_W-1:0] got_command;
    logic [WORD_W-1:0] got_object;

    modport source (
        output valid, status, from_channel, got_command, got_object,
        input  ready
    );

    modport sink (
        input  valid, status, from_channel, got_command, got_object,
        output ready
    );
endinterface

/* sv/mcmb_ctrl.sv */
`timescale 1ns / 1ps

module mcmb_ctrl
    import mcmb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DONE = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/mcmb_dp.sv */
`timescale 1ns / 1ps

module mcmb_dp
    import mcmb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_status        o_status,
    input  logic              i_cfg_wr_en,
    input  logic [WORD_W-1:0] i_cfg_wr_data,
    input  logic              i_command,
    input  logic [CHAN_W-1:0] i_channel,
    input  logic [WORD_W-1:0] i_message_command,
    input  logic [WORD_W-1:0] i_message_object,
    input  logic [WORD_W-1:0] i_receive_mask,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [STAT_W-1:0] o_stat,
    output logic [CHAN_W-1:0] o_from_channel,
    output logic [WORD_W-1:0] o_got_command,
    output logic [WORD_W-1:0] o_got_object
);

    logic [WORD_W-1:0]   r_open;
    logic [WORD_W-1:0]   r_ready_bits;
    logic [PTR_W-1:0]    r_head [CHANNELS];
    logic [PTR_W-1:0]    r_tail [CHANNELS];
    logic [CNT_W-1:0]    r_cnt  [CHANNELS];
    logic [2*WORD_W-1:0] r_mem  [MEM_DEPTH];
    logic [2*WORD_W-1:0] r_rdata;

    logic [STAT_W-1:0] r_res_stat;
    logic [CHAN_W-1:0] r_res_from;
    logic              r_res_hit;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_stat;
    logic [CHAN_W-1:0] r_out_from;
    logic [WORD_W-1:0] r_out_cmd;
    logic [WORD_W-1:0] r_out_obj;

    logic [WORD_W-1:0] w_open;
    logic              w_in_range;
    logic              w_send_valid;
    logic              w_full;
    logic              w_send_ok;
    logic [WORD_W-1:0] w_cand;
    logic [WORD_W-1:0] w_low;
    logic [CHAN_W-1:0] w_pick;
    logic              w_rx_hit;
    logic [CIDX_W-1:0] w_chan_idx;
    logic [CIDX_W-1:0] w_pick_idx;
    logic [CIDX_W-1:0] w_idx;
    logic [PTR_W-1:0]  w_ptr;
    logic [ADDR_W-1:0] w_addr;
    logic [STAT_W-1:0] w_stat;

    assign w_open       = r_open & VALID_MASK;
    assign w_in_range   = 32'(i_channel) < 32'(CHANNELS);
    assign w_chan_idx   = i_channel[CIDX_W-1:0];
    assign w_send_valid = w_in_range && w_open[i_channel];
    assign w_full       = r_cnt[w_chan_idx] == CNT_W'(QUEUE_DEPTH);
    assign w_send_ok    = (i_command == OP_SEND) && w_send_valid && !w_full;

    // lowest ready channel in the mask: isolate the lowest set bit, then encode
    assign w_cand = r_ready_bits & i_receive_mask & VALID_MASK;
    assign w_low  = w_cand & (~w_cand + 32'd1);

    always_comb begin
        w_pick = '0;
        for (int b = 0; b < CHAN_W; b++) begin
            for (int i = 0; i < WORD_W; i++) begin
                if (((i >> b) & 1) == 1) begin
                    w_pick[b] = w_pick[b] | w_low[i];
                end
            end
        end
    end

    assign w_pick_idx = w_pick[CIDX_W-1:0];
    assign w_rx_hit   = (i_command == OP_RECV) && (w_cand != '0)
                        && (r_cnt[w_pick_idx] != '0);

    assign w_idx  = (i_command == OP_RECV) ? w_pick_idx : w_chan_idx;
    assign w_ptr  = (i_command == OP_RECV) ? r_head[w_idx] : r_tail[w_idx];
    assign w_addr = ADDR_W'(32'(w_idx) * QUEUE_DEPTH) + ADDR_W'(w_ptr);

    always_comb begin
        if (i_command == OP_RECV) begin
            w_stat = w_rx_hit ? ST_OK : ST_NONE;
        end else if (!w_send_valid) begin
            w_stat = ST_INVALID;
        end else if (w_full) begin
            w_stat = ST_FULL;
        end else begin
            w_stat = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_send_ok) begin
            r_mem[w_addr] <= {i_message_command, i_message_object};
        end
        if (i_cmd.exec && w_rx_hit) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= '0;
            r_ready_bits <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_cnt[c]  <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_open <= i_cfg_wr_data;
            end
            if (i_cmd.exec && w_send_ok) begin
                r_tail[w_idx]          <= f_next_ptr(r_tail[w_idx]);
                r_cnt[w_idx]           <= r_cnt[w_idx] + CNT_W'(1);
                r_ready_bits[i_channel] <= 1'b1;
            end
            if (i_cmd.exec && w_rx_hit) begin
                r_head[w_idx] <= f_next_ptr(r_head[w_idx]);
                r_cnt[w_idx]  <= r_cnt[w_idx] - CNT_W'(1);
                if (r_cnt[w_idx] == CNT_W'(1)) begin
                    r_ready_bits[w_pick] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_stat <= w_stat;
            r_res_from <= w_rx_hit ? w_pick : '0;
            r_res_hit  <= w_rx_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_stat <= r_res_stat;
            r_out_from <= r_res_from;
            r_out_cmd  <= r_res_hit ? r_rdata[2*WORD_W-1:WORD_W] : '0;
            r_out_obj  <= r_res_hit ? r_rdata[WORD_W-1:0] : '0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_stat            = r_out_stat;
    assign o_from_channel    = r_out_from;
    assign o_got_command     = r_out_cmd;
    assign o_got_object      = r_out_obj;

    a_no_ready_chan0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ready_bits[0])
        else $error("channel zero marked ready");

    a_hit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (i_command == OP_RECV) && (w_cand != '0)) |-> w_rx_hit)
        else $error("ready channel has an empty queue");

    a_send_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_send_ok) |=> r_ready_bits[$past(i_channel)])
        else $error("send did not mark channel ready");

    a_load_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> !i_cmd.exec)
        else $error("two operations issued back to back");

endmodule

/* sv/multi_channel_message_mailbox_unit.sv */
`timescale 1ns / 1ps

// Message mailbox with CHANNELS-1 usable channels (channel 0 is reserved),
// each a FIFO of QUEUE_DEPTH command/object word pairs.
// i_req carries one operation per beat: a send (command 0) to a channel, or
// a receive (command 1) that takes the oldest message of the lowest-numbered
// non-empty channel in receive_mask. o_rsp returns one beat per request with
// a status (ok, invalid channel, channel full, nothing ready) and, for a
// successful receive, the channel and the message words.
// The user writes the open-channel register through i_cfg_wr_en /
// i_cfg_wr_data only while the block is idle; the block does not enforce it.
// Sequence: a request is accepted in S_IDLE, where a receive reads the message
// RAM into a register and the status and channel are registered; in S_DONE the
// result is loaded into the output register once that register is free, and
// the load sets o_rsp.valid. A new request is taken once that response has
// been loaded.
// If the receiver stalls, the response holds in the output register; one more
// request is accepted and its result holds in the datapath, and any request
// after that waits until the result can be loaded.
// Reset empties every queue, clears all ready bits and closes all channels;
// message RAM contents are left as they are.
module multi_channel_message_mailbox_unit
    import mcmb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [WORD_W-1:0] i_cfg_wr_data,
    mcmb_in_if.sink           i_req,
    mcmb_out_if.source        o_rsp
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    mcmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mcmb_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_command         (i_req.command),
        .i_channel         (i_req.channel),
        .i_message_command (i_req.message_command),
        .i_message_object  (i_req.message_object),
        .i_receive_mask    (i_req.receive_mask),
        .i_out_ready       (o_rsp.ready),
        .o_out_valid       (o_rsp.valid),
        .o_stat            (o_rsp.status),
        .o_from_channel    (o_rsp.from_channel),
        .o_got_command     (o_rsp.got_command),
        .o_got_object      (o_rsp.got_object)
    );

endmodule

/* sim/tb_multi_channel_message_mailbox_unit.sv */
`timescale 1ns / 1ps

module tb_multi_channel_message_mailbox_unit;
    import mcmb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int SEGMENT        = 32;

    typedef struct packed {
        logic              command;
        logic [CHAN_W-1:0] channel;
        logic [WORD_W-1:0] msg_cmd;
        logic [WORD_W-1:0] msg_obj;
        logic [WORD_W-1:0] rx_mask;
    } t_mb_op;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CHAN_W-1:0] from_channel;
        logic [WORD_W-1:0] got_command;
        logic [WORD_W-1:0] got_object;
    } t_mb_rsp;

    typedef enum logic {ROW_OP, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [4:0]        reps;
        logic              typed;
        t_mb_op            op;
        t_mb_rsp           rsp;
        logic [WORD_W-1:0] open_val;
    } t_dir_row;

    // Rows with typed set carry their own response; the rest go through the predictor.
    // A repeated row adds the repeat index to the command word and XORs it into the object word.
    localparam t_dir_row DIR_ROWS [15] = '{
        '{ROW_OP, 5'd1, 1'b1, '{OP_RECV, 5'd0, 32'd0, 32'd0, 32'hFFFF_FFFF},
          '{ST_NONE, 5'd0, 32'd0, 32'd0}, 32'd0},
        '{ROW_OP, 5'd1, 1'b1, '{OP_SEND, 5'd5, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd0},
          '{ST_INVALID, 5'd0, 32'd0, 32'd0}, 32'd0},
        // open everything, bit 0 included: channel zero must stay closed
        '{ROW_CFG, 5'd0, 1'b0, '0, '0, 32'hFFFF_FFFF},
        '{ROW_OP, 5'd1, 1'b1, '{OP_SEND, 5'd0, 32'h1234_5678, 32'h9ABC_DEF0, 32'd0},
          '{ST_INVALID, 5'd0, 32'd0, 32'd0}, 32'd0},
        '{ROW_OP, 5'd1, 1'b1, '{OP_SEND, 5'd31, 32'hFFFF_FFFF, 32'h0000_0000, 32'd0},
          '{ST_OK, 5'd0, 32'd0, 32'd0}, 32'd0},
        '{ROW_OP, 5'd1, 1'b1, '{OP_SEND, 5'd1, 32'h0000_0000, 32'hFFFF_FFFF, 32'd0},
          '{ST_OK, 5'd0, 32'd0, 32'd0}, 32'd0},
        '{ROW_OP, 5'd1, 1'b1, '{OP_RECV, 5'd0, 32'd0, 32'd0, 32'h0000_0001},
          '{ST_NONE, 5'd0, 32'd0, 32'd0}, 32'd0},
        '{ROW_OP, 5'd1, 1'b1, '{OP_RECV, 5'd31, 32'd0, 32'd0, 32'h0000_0000},
          '{ST_NONE, 5'd0, 32'd0, 32'd0}, 32'd0},
        '{ROW_OP, 5'd1, 1'b1, '{OP_RECV, 5'd0, 32'd0, 32'd0, 32'hFFFF_FFFF},
          '{ST_OK, 5'd1, 32'h0000_0000, 32'hFFFF_FFFF}, 32'd0},
        '{ROW_OP, 5'd1, 1'b1, '{OP_RECV, 5'd0, 32'd0, 32'd0, 32'h8000_0000},
          '{ST_OK, 5'd31, 32'hFFFF_FFFF, 32'h0000_0000}, 32'd0},
        // fill channel 7 to the brim, then one more
        '{ROW_OP, 5'd16, 1'b0, '{OP_SEND, 5'd7, 32'h0700_0000, 32'h0000_0700, 32'd0},
          '0, 32'd0},
        '{ROW_OP, 5'd1, 1'b1, '{OP_SEND, 5'd7, 32'h0700_00FF, 32'hFF00_0700, 32'd0},
          '{ST_FULL, 5'd0, 32'd0, 32'd0}, 32'd0},
        // close all: a queued message on channel 7 must still come out
        '{ROW_CFG, 5'd0, 1'b0, '0, '0, 32'h0000_0000},
        '{ROW_OP, 5'd1, 1'b1, '{OP_SEND, 5'd7, 32'h0000_0001, 32'h0000_0002, 32'd0},
          '{ST_INVALID, 5'd0, 32'd0, 32'd0}, 32'd0},
        '{ROW_OP, 5'd1, 1'b0, '{OP_RECV, 5'd0, 32'd0, 32'd0, 32'h0000_0080},
          '0, 32'd0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [WORD_W-1:0] i_cfg_wr_data;

    mcmb_in_if  req_if ();
    mcmb_out_if rsp_if ();

    // Predictor state
    logic [WORD_W-1:0]   open_model;
    logic [WORD_W-1:0]   ready_model;
    logic [2*WORD_W-1:0] chan_fifo [CHANNELS][$];
    t_mb_rsp             pending_rsp_q [$];

    int                  tx_idle_pct  = 0;
    int                  rx_stall_pct = 0;
    bit                  rx_hold      = 1'b0;
    int                  mismatch_cnt = 0;
    int                  idle_cycles  = 0;
    logic [CHAN_W-1:0]   hot_ch [3];

    multi_channel_message_mailbox_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_mb_rsp mailbox_outcome(input t_mb_op op);
        t_mb_rsp           r;
        logic [WORD_W-1:0] cand;
        int                sel;
        r = '0;
        if (op.command == OP_SEND) begin
            if (int'(op.channel) >= CHANNELS
                    || !(open_model[op.channel] && VALID_MASK[op.channel])) begin
                r.status = ST_INVALID;
            end else if (chan_fifo[op.channel].size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                chan_fifo[op.channel].push_back({op.msg_cmd, op.msg_obj});
                ready_model[op.channel] = 1'b1;
            end
        end else begin
            cand = ready_model & op.rx_mask & VALID_MASK;
            if (cand == '0) begin
                r.status = ST_NONE;
            end else begin
                sel = 0;
                while (!cand[sel]) sel++;
                {r.got_command, r.got_object} = chan_fifo[sel].pop_front();
                r.from_channel = CHAN_W'(sel);
                if (chan_fifo[sel].size() == 0) ready_model[sel] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] any_open_channel();
        logic [CHAN_W-1:0] c;
        c = CHAN_W'($urandom_range(31));
        if ((open_model & VALID_MASK) != '0) begin
            while (!(open_model[c] && VALID_MASK[c])) c = CHAN_W'($urandom_range(31));
        end
        return c;
    endfunction

    // Filling segments lean on sends, draining segments on receives.
    function automatic t_mb_op random_op(input bit filling);
        t_mb_op op;
        int     roll;
        op.msg_cmd = $urandom;
        op.msg_obj = $urandom;
        op.command = ($urandom_range(99) < (filling ? 15 : 75)) ? OP_RECV : OP_SEND;
        op.channel = ($urandom_range(99) < 85) ? hot_ch[$urandom_range(2)]
                                               : CHAN_W'($urandom_range(31));
        roll = $urandom_range(9);
        if (roll < 5) begin
            op.rx_mask = '1;
        end else if (roll < 7) begin
            op.rx_mask = WORD_W'(1) << hot_ch[$urandom_range(2)];
        end else begin
            op.rx_mask = $urandom;
        end
        return op;
    endfunction

    // Leaves valid high after the beat; a drain lowers it, or the next call when it idles.
    task automatic push_op(input t_mb_op op, input bit typed, input t_mb_rsp typed_rsp);
        t_mb_rsp pred;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        req_if.valid           <= 1'b1;
        req_if.command         <= op.command;
        req_if.channel         <= op.channel;
        req_if.message_command <= op.msg_cmd;
        req_if.message_object  <= op.msg_obj;
        req_if.receive_mask    <= op.rx_mask;
        do @(posedge i_clk); while (!req_if.ready);
        pred = mailbox_outcome(op);
        pending_rsp_q.push_back(typed ? typed_rsp : pred);
    endtask

    task automatic drain_responses();
        req_if.valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_open(input logic [WORD_W-1:0] val);
        drain_responses();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        open_model = val;
    endtask

    task automatic run_directed();
        t_mb_op op;
        for (int r = 0; r < $size(DIR_ROWS); r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                write_open(DIR_ROWS[r].open_val);
            end else begin
                for (int k = 0; k < int'(DIR_ROWS[r].reps); k++) begin
                    op = DIR_ROWS[r].op;
                    op.msg_cmd = op.msg_cmd + WORD_W'(k);
                    op.msg_obj = op.msg_obj ^ WORD_W'(k);
                    push_op(op, DIR_ROWS[r].typed, DIR_ROWS[r].rsp);
                end
            end
        end
    endtask

    task automatic run_random(input logic [WORD_W-1:0] open_val, input int tx_pct,
                              input int rx_pct, input int count, input bit squeeze);
        write_open(open_val);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        hot_ch[0] = any_open_channel();
        hot_ch[1] = any_open_channel();
        hot_ch[2] = hot_ch[0];
        if (squeeze) begin
            // hold the response side while requests keep coming
            fork
                begin
                    rx_hold = 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    rx_hold = 1'b0;
                end
            join_none
        end
        for (int n = 0; n < count; n++) begin
            if (squeeze && n == count / 2) drain_responses();
            push_op(random_op((n / SEGMENT) % 2 == 0), 1'b0, '0);
        end
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        i_cfg_wr_en            <= 1'b0;
        i_cfg_wr_data          <= '0;
        req_if.valid           <= 1'b0;
        req_if.command         <= OP_SEND;
        req_if.channel         <= '0;
        req_if.message_command <= '0;
        req_if.message_object  <= '0;
        req_if.receive_mask    <= '0;
        open_model  = '0;
        ready_model = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        run_random(32'hFFFF_FFFE, 0, 0, 90, 1'b0);
        run_random($urandom, 87, 0, 70, 1'b0);
        run_random(32'h8000_0002, 0, 87, 70, 1'b0);
        run_random($urandom, 7, 7, 80, 1'b0);
        run_random(32'hFFFF_FFFF, 0, 0, 100, 1'b1);
        run_random(32'h0000_0000, 7, 7, 30, 1'b0);

        drain_responses();
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_mb_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual status %0d channel %0d",
                         $time, rsp_if.status, rsp_if.from_channel);
                mismatch_cnt++;
            end else begin
                want = pending_rsp_q.pop_front();
                if (rsp_if.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_if.status);
                    mismatch_cnt++;
                end
                if (rsp_if.from_channel !== want.from_channel) begin
                    $display("%0t: from_channel expected %0d actual %0d",
                             $time, want.from_channel, rsp_if.from_channel);
                    mismatch_cnt++;
                end
                if (rsp_if.got_command !== want.got_command) begin
                    $display("%0t: got_command expected %h actual %h",
                             $time, want.got_command, rsp_if.got_command);
                    mismatch_cnt++;
                end
                if (rsp_if.got_object !== want.got_object) begin
                    $display("%0t: got_object expected %h actual %h",
                             $time, want.got_object, rsp_if.got_object);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Count cycles with no beat on either side; the test fails when the count reaches its limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* files.f */
sv/mcmb_pkg.sv
sv/mcmb_in_if.sv
sv/mcmb_out_if.sv
sv/mcmb_ctrl.sv
sv/mcmb_dp.sv
sv/multi_channel_message_mailbox_unit.sv
sim/tb_multi_channel_message_mailbox_unit.sv
